// ===== sv/sus_pkg.sv =====
package sus_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_FULL      = 3'd4,
    ST_POPPED    = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  // Broadcast to every cell for one beat.
  typedef struct packed {
    logic                     accept;
    op_t                      op;
    logic signed [DATA_W-1:0] value;
    logic                     hit;
    logic                     full;
  } cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                     valid;
    logic                     gt;
    logic signed [DATA_W-1:0] value;
  } link_t;

endpackage

// ===== sv/sus_cell.sv =====
module sus_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sus_pkg::cmd_t                     cmd,
  input  sus_pkg::link_t                    left,
  input  sus_pkg::link_t                    right,
  output sus_pkg::link_t                    self_o,
  output logic                              eq_o,
  output logic                              valid_nxt_o,
  output logic signed [sus_pkg::DATA_W-1:0] value_nxt_o
);
  import sus_pkg::*;

  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic                     valid_r, valid_nxt;
  logic                     gt, eq;

  assign gt = valid_r && (value_r > cmd.value);
  assign eq = valid_r && (value_r == cmd.value);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (cmd.accept) begin
      unique case (cmd.op)
        OP_INSERT: begin
          if (!cmd.hit && !cmd.full && (gt || (!valid_r && left.valid))) begin
            value_nxt = left.gt ? left.value : cmd.value;
            valid_nxt = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (cmd.hit && (gt || eq)) begin
            value_nxt = right.value;
            valid_nxt = right.valid;
          end
        end
        OP_POP: begin
          if (valid_r) begin
            value_nxt = right.value;
            valid_nxt = right.valid;
          end
        end
        OP_CLEAR: begin
          valid_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign self_o      = '{valid: valid_r, gt: gt, value: value_r};
  assign eq_o        = eq;
  assign valid_nxt_o = valid_nxt;
  assign value_nxt_o = value_nxt;

endmodule

// ===== sv/sorted_unique_set_unit.sv =====
// Sorted set of up to 16 distinct signed 32-bit values, kept in a row of
// compare-and-shift cells, smallest value in the first cell.
// Input stream: one beat is one command (insert, remove, pop smallest, clear).
// Output stream: exactly one result beat per command, in order, carrying the
// status, the smallest value after the command (zero when empty), an empty
// flag and the element count.
// Every cell compares its entry with the command value at once and takes its
// own, its left or its right neighbor's entry, all in parallel: the result is
// registered and valid in the cycle after the input beat, and one command
// is taken per cycle as long as the result is taken.
// The result sits in an output register; while the receiver stalls, that
// register holds and in_tready stays low, so no beat is dropped.
// Reset empties the set at once (no clearing pass) and drops any pending
// result; in_tready is high in the first cycle after reset.
module sorted_unique_set_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] opcode, [33:2] value, [39:34] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [2:0] status, [34:3] head_value, [35] is_empty,
                                  // [40:36] entry_count, [47:41] zero
);
  import sus_pkg::*;

  logic                     acc;
  cmd_t                     cmd;
  link_t                    links [CAPACITY];
  link_t                    lefts [CAPACITY];
  link_t                    rights[CAPACITY];
  logic [CAPACITY-1:0]      eq_vec, valid_vec, valid_nxt_vec;
  logic signed [DATA_W-1:0] value_nxt [CAPACITY];
  logic                     hit, full;

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  status_t                  status;
  logic                     out_valid_r;
  status_t                  status_r;
  logic signed [DATA_W-1:0] head_r;
  logic                     empty_r;
  logic [CNT_W-1:0]         count_r;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign hit       = |eq_vec;
  assign full      = valid_vec[CAPACITY-1];

  assign cmd = '{accept: acc, op: op_t'(in_tdata[1:0]),
                 value: $signed(in_tdata[33:2]), hit: hit, full: full};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '{valid: 1'b1, gt: 1'b0, value: '0};
    end else begin : g_mid_l
      assign lefts[i] = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rights[i] = '{valid: 1'b0, gt: 1'b0, value: '0};
    end else begin : g_mid_r
      assign rights[i] = links[i+1];
    end

    sus_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left        (lefts[i]),
      .right       (rights[i]),
      .self_o      (links[i]),
      .eq_o        (eq_vec[i]),
      .valid_nxt_o (valid_nxt_vec[i]),
      .value_nxt_o (value_nxt[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    status  = ST_EMPTY;
    unique case (cmd.op)
      OP_INSERT: begin
        if (hit) begin
          status = ST_DUPLICATE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          status  = ST_INSERTED;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          status  = ST_REMOVED;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          status = ST_ABSENT;
        end
      end
      OP_POP: begin
        if (valid_vec[0]) begin
          status  = ST_POPPED;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        cnt_r <= cnt_nxt;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status;
      head_r   <= valid_nxt_vec[0] ? value_nxt[0] : '0;
      empty_r  <= !valid_nxt_vec[0];
      count_r  <= cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, count_r, empty_r, head_r, status_r};

  logic [CAPACITY:0] fill_mask;
  assign fill_mask = ((CAPACITY+1)'(1) << cnt_r) - (CAPACITY+1)'(1);

  a_fill_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    valid_vec == fill_mask[CAPACITY-1:0])
    else $error("occupied cells do not match the element count");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    acc && cmd.op == OP_REMOVE && hit |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("successful remove did not shrink the set");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(eq_vec))
    else $error("value stored in more than one cell");

  a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && empty_r |-> head_r == '0 && count_r == '0)
    else $error("empty result carries a head or a count");

endmodule
